// File: rtl/arithmetic_expression_tokenizer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the expression tokenizer
// Clocked on clk, held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ARITHMETIC_EXPRESSION_TOKENIZER_DEFINES_SVH
`define ARITHMETIC_EXPRESSION_TOKENIZER_DEFINES_SVH

// same-cycle implication
`define AET_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AET_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/aet_pkg.sv
// ----------------------------------------------------------------------------
// aet_pkg
// Shared types, codes and character classes of the expression tokenizer.
// ----------------------------------------------------------------------------
package aet_pkg;

	localparam int POSITION_BITS_DEF = 16;

	// result queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;
	localparam int MAX_RESULTS = 3;

	// token kinds
	localparam logic [3:0] KIND_NUM   = 4'd0;
	localparam logic [3:0] KIND_IDENT = 4'd1;
	localparam logic [3:0] KIND_PLUS  = 4'd2;
	localparam logic [3:0] KIND_MINUS = 4'd3;
	localparam logic [3:0] KIND_MUL   = 4'd4;
	localparam logic [3:0] KIND_DIV   = 4'd5;
	localparam logic [3:0] KIND_POW   = 4'd6;
	localparam logic [3:0] KIND_MOD   = 4'd7;
	localparam logic [3:0] KIND_LPAR  = 4'd8;
	localparam logic [3:0] KIND_RPAR  = 4'd9;
	localparam logic [3:0] KIND_EQ    = 4'd10;
	localparam logic [3:0] KIND_COMMA = 4'd11;
	localparam logic [3:0] KIND_END   = 4'd12;

	// error codes
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
	localparam logic [1:0] ERR_EXPONENT   = 2'd2;

	// scanner modes
	localparam logic [3:0] M_IDLE     = 4'd0;
	localparam logic [3:0] M_INT      = 4'd1;
	localparam logic [3:0] M_INT_DOT  = 4'd2;
	localparam logic [3:0] M_FRAC     = 4'd3;
	localparam logic [3:0] M_EXP      = 4'd4;
	localparam logic [3:0] M_EXP_SIGN = 4'd5;
	localparam logic [3:0] M_EXP_DIG  = 4'd6;
	localparam logic [3:0] M_IDENT    = 4'd7;
	localparam logic [3:0] M_STAR     = 4'd8;
	localparam logic [3:0] M_DOT_LEAD = 4'd9;
	localparam logic [3:0] M_ERROR    = 4'd10;

	// characters
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_E_LO  = 8'h65;
	localparam logic [7:0] CH_E_UP  = 8'h45;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// one result item
	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
		logic [1:0]  err;
		logic [7:0]  bad;
		logic        last;
	} res_t;

	// single-character operator lookup
	typedef struct packed {
		logic       hit;
		logic [3:0] kind;
	} op_t;

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		is_alpha = c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		is_space = (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
	endfunction

	function automatic logic is_exp(input logic [7:0] c);
		is_exp = (c == CH_E_LO) || (c == CH_E_UP);
	endfunction

	function automatic logic is_ident(input logic [7:0] c);
		is_ident = is_digit(c) || is_alpha(c) || (c == CH_UNDER);
	endfunction

	function automatic op_t op_lookup(input logic [7:0] c);
		op_t o;
		o.hit  = 1'b1;
		o.kind = KIND_NUM;
		case (c)
			CH_PLUS:  o.kind = KIND_PLUS;
			CH_MINUS: o.kind = KIND_MINUS;
			CH_SLASH: o.kind = KIND_DIV;
			CH_CARET: o.kind = KIND_POW;
			CH_PCT:   o.kind = KIND_MOD;
			CH_LPAR:  o.kind = KIND_LPAR;
			CH_RPAR:  o.kind = KIND_RPAR;
			CH_EQ:    o.kind = KIND_EQ;
			CH_COMMA: o.kind = KIND_COMMA;
			default:  o.hit  = 1'b0;
		endcase
		op_lookup = o;
	endfunction

endpackage

// File: rtl/aet_core.sv
// ----------------------------------------------------------------------------
// aet_core
// Scanner state and the single-pass decode of one byte and/or end marker
// into up to three results.
// ----------------------------------------------------------------------------
module aet_core #(
	parameter int POSITION_BITS = aet_pkg::POSITION_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       char_byte,
	input  logic             has_char,
	input  logic             is_last,
	output aet_pkg::res_t    res [aet_pkg::MAX_RESULTS],
	output logic [1:0]       res_count
);
	import aet_pkg::*;

	localparam int PB    = POSITION_BITS;
	localparam int EXT_W = (PB > 16) ? PB : 16;

	logic [3:0]    mode_q;
	logic [PB-1:0] begin_q;
	logic [PB-1:0] pos_q;

	// clamp a position to the 16-bit result field
	function automatic logic [15:0] clamp16(input logic [PB-1:0] v);
		logic [EXT_W-1:0] e;
		e = EXT_W'(v);
		clamp16 = (e > EXT_W'(17'h0FFFF)) ? 16'hFFFF : e[15:0];
	endfunction

	function automatic res_t mk(input logic [3:0] kind, input logic [PB-1:0] start,
			input logic [PB-1:0] len, input logic [1:0] err, input logic [7:0] bad);
		res_t r;
		r.kind  = kind;
		r.start = clamp16(start);
		r.len   = clamp16(len);
		r.err   = err;
		r.bad   = bad;
		r.last  = 1'b0;
		mk = r;
	endfunction

	function automatic logic [PB-1:0] prev(input logic [PB-1:0] v);
		prev = (v != '0) ? v - PB'(1) : v;
	endfunction

	logic [PB-1:0] pos_a;
	logic [PB-1:0] p_prev;
	logic [3:0]    mode_a;
	logic [PB-1:0] begin_a;
	res_t          a [2];
	logic [1:0]    na;

	// token started by this byte
	logic [3:0]    st_mode;
	logic          st_set_begin;
	logic          st_emit;
	res_t          st_res;
	op_t           op;

	res_t          f [3];
	logic [1:0]    nf;
	logic [3:0]    mode_n;
	logic [PB-1:0] begin_n;
	logic [PB-1:0] pos_n;
	logic [PB-1:0] prev_a;
	logic [2:0]    total;
	logic [2:0]    fidx;
	res_t          fnul;

	assign p_prev = prev(pos_q);
	assign op     = op_lookup(char_byte);
	assign fnul   = mk(KIND_NUM, '0, '0, ERR_NONE, 8'h00);

	// start of a fresh token
	always_comb begin
		st_mode      = M_IDLE;
		st_set_begin = 1'b0;
		st_emit      = 1'b0;
		st_res       = mk(op.kind, pos_q, PB'(1), ERR_NONE, 8'h00);
		if (is_space(char_byte)) begin
			st_mode = M_IDLE;
		end else if (is_digit(char_byte)) begin
			st_mode      = M_INT;
			st_set_begin = 1'b1;
		end else if (char_byte == CH_DOT) begin
			st_mode      = M_DOT_LEAD;
			st_set_begin = 1'b1;
		end else if (is_alpha(char_byte) || char_byte == CH_UNDER) begin
			st_mode      = M_IDENT;
			st_set_begin = 1'b1;
		end else if (char_byte == CH_STAR) begin
			st_mode      = M_STAR;
			st_set_begin = 1'b1;
		end else if (op.hit) begin
			st_emit = 1'b1;
		end else begin
			st_emit = 1'b1;
			st_mode = M_ERROR;
			st_res  = mk(KIND_NUM, pos_q, '0, ERR_UNEXPECTED, char_byte);
		end
	end

	// byte part
	always_comb begin
		pos_a   = pos_q;
		mode_a  = mode_q;
		begin_a = begin_q;
		a[0]    = fnul;
		a[1]    = st_res;
		na      = 2'd0;
		if (has_char) begin
			if (pos_q != '1)
				pos_a = pos_q + PB'(1);
			case (mode_q)
				M_INT, M_FRAC, M_EXP_DIG, M_IDENT: begin
					if (mode_q == M_IDENT && is_ident(char_byte)) begin
						mode_a = mode_q;
					end else if (mode_q != M_IDENT && is_digit(char_byte)) begin
						mode_a = mode_q;
					end else if (mode_q == M_INT && char_byte == CH_DOT) begin
						mode_a = M_INT_DOT;
					end else if ((mode_q == M_INT || mode_q == M_FRAC) &&
							is_exp(char_byte)) begin
						mode_a = M_EXP;
					end else begin
						a[0]    = mk((mode_q == M_IDENT) ? KIND_IDENT : KIND_NUM,
							begin_q, pos_q - begin_q, ERR_NONE, 8'h00);
						na      = st_emit ? 2'd2 : 2'd1;
						mode_a  = st_mode;
						begin_a = st_set_begin ? pos_q : begin_q;
					end
				end
				M_INT_DOT: begin
					if (is_digit(char_byte)) begin
						mode_a = M_FRAC;
					end else begin
						a[0]   = mk(KIND_NUM, begin_q, p_prev - begin_q, ERR_NONE, 8'h00);
						a[1]   = mk(KIND_NUM, p_prev, '0, ERR_UNEXPECTED, CH_DOT);
						na     = 2'd2;
						mode_a = M_ERROR;
					end
				end
				M_EXP: begin
					if (char_byte == CH_PLUS || char_byte == CH_MINUS) begin
						mode_a = M_EXP_SIGN;
					end else if (is_digit(char_byte)) begin
						mode_a = M_EXP_DIG;
					end else begin
						a[0]   = mk(KIND_NUM, begin_q, '0, ERR_EXPONENT, 8'h00);
						na     = 2'd1;
						mode_a = M_ERROR;
					end
				end
				M_EXP_SIGN: begin
					if (is_digit(char_byte)) begin
						mode_a = M_EXP_DIG;
					end else begin
						a[0]   = mk(KIND_NUM, begin_q, '0, ERR_EXPONENT, 8'h00);
						na     = 2'd1;
						mode_a = M_ERROR;
					end
				end
				M_STAR: begin
					if (char_byte == CH_STAR) begin
						a[0]   = mk(KIND_POW, begin_q, PB'(2), ERR_NONE, 8'h00);
						na     = 2'd1;
						mode_a = M_IDLE;
					end else begin
						a[0]    = mk(KIND_MUL, begin_q, PB'(1), ERR_NONE, 8'h00);
						na      = st_emit ? 2'd2 : 2'd1;
						mode_a  = st_mode;
						begin_a = st_set_begin ? pos_q : begin_q;
					end
				end
				M_DOT_LEAD: begin
					if (is_digit(char_byte)) begin
						mode_a = M_FRAC;
					end else begin
						a[0]   = mk(KIND_NUM, begin_q, '0, ERR_UNEXPECTED, CH_DOT);
						na     = 2'd1;
						mode_a = M_ERROR;
					end
				end
				M_ERROR: begin
					mode_a = M_ERROR;
				end
				default: begin
					a[0]    = st_res;
					na      = st_emit ? 2'd1 : 2'd0;
					mode_a  = st_mode;
					begin_a = st_set_begin ? pos_q : begin_q;
				end
			endcase
		end
	end

	assign prev_a = prev(pos_a);

	// end-of-expression part: flush pending token, then End unless an error
	always_comb begin
		f[0]    = fnul;
		f[1]    = mk(KIND_END, pos_a, '0, ERR_NONE, 8'h00);
		f[2]    = fnul;
		nf      = 2'd0;
		mode_n  = mode_a;
		begin_n = begin_a;
		pos_n   = pos_a;
		if (is_last) begin
			mode_n  = M_IDLE;
			begin_n = '0;
			pos_n   = '0;
			case (mode_a)
				M_INT, M_FRAC, M_EXP_DIG: begin
					f[0] = mk(KIND_NUM, begin_a, pos_a - begin_a, ERR_NONE, 8'h00);
					nf   = 2'd2;
				end
				M_IDENT: begin
					f[0] = mk(KIND_IDENT, begin_a, pos_a - begin_a, ERR_NONE, 8'h00);
					nf   = 2'd2;
				end
				M_STAR: begin
					f[0] = mk(KIND_MUL, begin_a, PB'(1), ERR_NONE, 8'h00);
					nf   = 2'd2;
				end
				M_INT_DOT: begin
					f[0] = mk(KIND_NUM, begin_a, prev_a - begin_a, ERR_NONE, 8'h00);
					f[1] = mk(KIND_NUM, prev_a, '0, ERR_UNEXPECTED, CH_DOT);
					nf   = 2'd2;
				end
				M_DOT_LEAD: begin
					f[0] = mk(KIND_NUM, begin_a, '0, ERR_UNEXPECTED, CH_DOT);
					nf   = 2'd1;
				end
				M_EXP, M_EXP_SIGN: begin
					f[0] = mk(KIND_NUM, begin_a, '0, ERR_EXPONENT, 8'h00);
					nf   = 2'd1;
				end
				M_ERROR: begin
					nf = 2'd0;
				end
				default: begin
					f[0] = f[1];
					nf   = 2'd1;
				end
			endcase
		end
	end

	// merge the two parts, keep the first three
	assign total = 3'(na) + 3'(nf);
	assign res_count = (total > 3'(MAX_RESULTS)) ? 2'(MAX_RESULTS) : total[1:0];

	always_comb begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			fidx = 3'(i) - 3'(na);
			if (3'(i) < 3'(na))
				res[i] = a[i[0]];
			else
				res[i] = f[fidx[1:0]];
			res[i].last = (2'(i) == res_count - 2'd1);
		end
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			begin_q <= '0;
			pos_q   <= '0;
		end else if (step) begin
			mode_q  <= mode_n;
			begin_q <= begin_n;
			pos_q   <= pos_n;
		end
	end

endmodule

// File: rtl/arithmetic_expression_tokenizer.sv
// ----------------------------------------------------------------------------
// arithmetic_expression_tokenizer
// Byte-stream lexer for arithmetic expressions, token kind/start/length out.
// ----------------------------------------------------------------------------
// Takes one byte (or a bare end marker) per item and emits tokens as kind,
// start position and length; the token text stays in the caller's buffer.
// An item is registered on entry and decoded from that register straight
// into a four-entry result queue. Its first result is offered as soon as
// the item's results have been written into the queue. One item per cycle
// is taken as long as the queue has room for that item's results. The
// output drains one result per cycle while the receiver is ready. Items that
// yield two or three results (a token closed by an operator, a flush at end
// of expression) are absorbed by the queue while it has room. Once the queue
// is full, the input waits until the queue has room for an item's results.
// After an error every byte is dropped until the end marker, which then
// produces nothing.
module arithmetic_expression_tokenizer #(
	parameter int POSITION_BITS = aet_pkg::POSITION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
	input  logic [0:0]  s_axis_tuser,   // [0] has_char
	input  logic        s_axis_tlast,   // is_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [15:0] token_start, [31:16] token_length,
	                                    // [39:32] bad_char
	output logic [5:0]  m_axis_tuser,   // [3:0] token_kind, [5:4] error_code
	output logic        m_axis_tlast    // last_of_run
);
	import aet_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       has_s1;
	logic       last_s1;

	// result queue
	res_t                queue_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q;
	logic [QUEUE_AW-1:0] rd_q;
	logic [QUEUE_AW:0]   cnt_q;

	res_t       res [MAX_RESULTS];
	logic [1:0] res_count;
	logic       pop;
	logic       step;
	logic [QUEUE_AW:0] room;
	res_t       head;

	aet_core #(
		.POSITION_BITS(POSITION_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.char_byte (char_s1),
		.has_char  (has_s1),
		.is_last   (last_s1),
		.res       (res),
		.res_count (res_count)
	);

	// handshake
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign room          = (QUEUE_AW+1)'(QUEUE_DEPTH) - cnt_q + (QUEUE_AW+1)'(pop);
	assign step          = valid_s1 && ((QUEUE_AW+1)'(res_count) <= room);
	assign s_axis_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			has_s1  <= s_axis_tuser[0];
			last_s1 <= s_axis_tlast;
		end
	end

	// queue payload
	always_ff @(posedge clk) begin
		if (step) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				if (2'(i) < res_count)
					queue_q[wr_q + QUEUE_AW'(i)] <= res[i];
			end
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (step)
				wr_q <= wr_q + QUEUE_AW'(res_count);
			if (pop)
				rd_q <= rd_q + QUEUE_AW'(1);
			cnt_q <= cnt_q + (step ? (QUEUE_AW+1)'(res_count) : '0)
				- (QUEUE_AW+1)'(pop);
		end
	end

	// output side
	assign head          = queue_q[rd_q];
	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tdata  = {head.bad, head.len, head.start};
	assign m_axis_tuser  = {head.err, head.kind};
	assign m_axis_tlast  = head.last;

endmodule

// File: rtl/aet_checker.sv
// ----------------------------------------------------------------------------
// aet_checker
// Port-level checks on the tokenizer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "arithmetic_expression_tokenizer_defines.svh"

module aet_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic [5:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	import aet_pkg::*;

	logic        stalled;
	logic [46:0] out_word;
	logic [3:0]  out_kind;
	logic [1:0]  out_err;
	logic [15:0] out_len;
	logic [7:0]  out_bad;
	logic        is_err;
	logic        no_unexp_err;

	// result fields
	assign stalled      = m_axis_tvalid && !m_axis_tready;
	assign out_word     = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
	assign out_kind     = m_axis_tuser[3:0];
	assign out_err      = m_axis_tuser[5:4];
	assign out_len      = m_axis_tdata[31:16];
	assign out_bad      = m_axis_tdata[39:32];
	assign is_err       = m_axis_tvalid && (out_err != ERR_NONE);
	assign no_unexp_err = m_axis_tvalid && (out_err != ERR_UNEXPECTED);

	// a stalled result holds
	`AET_ASSERT_NXT(a_out_hold, stalled, m_axis_tvalid && $stable(out_word), "result changed while stalled")

	// kind stays within the token set
	`AET_ASSERT_IMP(a_kind_range, m_axis_tvalid, out_kind <= KIND_END, "token kind out of range")

	// error results carry kind zero and no length
	`AET_ASSERT_IMP(a_err_shape, is_err, out_kind == KIND_NUM && out_len == 16'h0000, "malformed error result")

	// offending byte only with unexpected-character errors
	`AET_ASSERT_IMP(a_bad_char, no_unexp_err, out_bad == 8'h00, "bad_char without unexpected-character error")

endmodule

bind arithmetic_expression_tokenizer aet_checker u_aet_checker (.*);

// File: bench/token_checker.sv
// ----------------------------------------------------------------------------
// token_checker
// Scoreboard for the expression tokenizer: predicts tokens, compares results.
// ----------------------------------------------------------------------------
// Watches both stream channels. Every byte item taken by the tokenizer is run
// through a cycle-free lexer model kept here, and the tokens it should give
// are queued. Every result item is checked field by field against the oldest
// queued token. The failure count and the number of tokens still due are
// handed to the top.
module token_checker #(
	parameter int POSITION_BITS = aet_pkg::POSITION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] char_byte
	input  logic [0:0]  s_tuser,    // [0] has_char
	input  logic        s_tlast,    // is_last
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,    // [15:0] token_start, [31:16] token_length,
	                                // [39:32] bad_char
	input  logic [5:0]  m_tuser,    // [3:0] token_kind, [5:4] error_code
	input  logic        m_tlast,    // last_of_run
	output int          fails,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import aet_pkg::*;

	localparam int unsigned POS_TOP = int'((64'd1 << POSITION_BITS) - 64'd1);

	// lexer model state
	logic [3:0]  scan;
	int unsigned tok_pos;
	int unsigned byte_pos;

	// tokens of the item being modelled, then all tokens still to arrive
	res_t        step_res [MAX_RESULTS];
	int          step_n;
	res_t        tokens_due [$];

	initial begin
		fails    = 0;
		pending  = 0;
		scan     = M_IDLE;
		tok_pos  = 0;
		byte_pos = 0;
	end

	// character classes
	function automatic bit ch_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic bit ch_alpha(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic bit ch_blank(input logic [7:0] c);
		return (c == " ") || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	function automatic bit ch_word(input logic [7:0] c);
		return ch_digit(c) || ch_alpha(c) || (c == CH_UNDER);
	endfunction

	function automatic bit ch_exp(input logic [7:0] c);
		return (c == CH_E_LO) || (c == CH_E_UP);
	endfunction

	function automatic logic [15:0] clamp_pos(input int unsigned v);
		return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
	endfunction

	// queue one token for the current item, at most three per item
	function automatic void add_token(input logic [3:0] kind, input int unsigned start,
			input int unsigned len, input logic [1:0] err, input logic [7:0] bad);
		res_t r;
		if (step_n >= MAX_RESULTS)
			return;
		r.kind  = kind;
		r.start = clamp_pos(start);
		r.len   = clamp_pos(len);
		r.err   = err;
		r.bad   = bad;
		r.last  = 1'b0;
		step_res[step_n] = r;
		step_n++;
	endfunction

	// an error always lands in the discard state
	function automatic void add_error(input int unsigned start, input logic [1:0] code,
			input logic [7:0] ch);
		add_token(KIND_NUM, start, 0, code, (code == ERR_UNEXPECTED) ? ch : 8'h00);
		scan = M_ERROR;
	endfunction

	// first byte of a new token
	function automatic void open_token(input logic [7:0] c, input int unsigned p);
		logic [3:0] kind;
		bit         single;
		scan   = M_IDLE;
		kind   = KIND_NUM;
		single = 1'b1;
		if (ch_blank(c)) begin
		end else if (ch_digit(c)) begin
			scan    = M_INT;
			tok_pos = p;
		end else if (c == CH_DOT) begin
			scan    = M_DOT_LEAD;
			tok_pos = p;
		end else if (ch_alpha(c) || c == CH_UNDER) begin
			scan    = M_IDENT;
			tok_pos = p;
		end else if (c == CH_STAR) begin
			scan    = M_STAR;
			tok_pos = p;
		end else begin
			case (c)
				CH_PLUS:  kind = KIND_PLUS;
				CH_MINUS: kind = KIND_MINUS;
				CH_SLASH: kind = KIND_DIV;
				CH_CARET: kind = KIND_POW;
				CH_PCT:   kind = KIND_MOD;
				CH_LPAR:  kind = KIND_LPAR;
				CH_RPAR:  kind = KIND_RPAR;
				CH_EQ:    kind = KIND_EQ;
				CH_COMMA: kind = KIND_COMMA;
				default:  single = 1'b0;
			endcase
			if (single)
				add_token(kind, p, 1, ERR_NONE, 8'h00);
			else
				add_error(p, ERR_UNEXPECTED, c);
		end
	endfunction

	// one byte at position p, in the current scan state
	function automatic void scan_byte(input logic [7:0] c, input int unsigned p);
		int unsigned back;
		back = (p > 0) ? p - 1 : 0;
		case (scan)
			M_INT, M_FRAC, M_EXP_DIG: begin
				if (ch_digit(c)) begin
				end else if (c == CH_DOT && scan == M_INT) begin
					scan = M_INT_DOT;
				end else if (ch_exp(c) && scan != M_EXP_DIG) begin
					scan = M_EXP;
				end else begin
					add_token(KIND_NUM, tok_pos, p - tok_pos, ERR_NONE, 8'h00);
					open_token(c, p);
				end
			end
			M_INT_DOT: begin
				// a dot with no digit after it: number first, then the dot
				if (ch_digit(c)) begin
					scan = M_FRAC;
				end else begin
					add_token(KIND_NUM, tok_pos, back - tok_pos, ERR_NONE, 8'h00);
					add_error(back, ERR_UNEXPECTED, CH_DOT);
				end
			end
			M_EXP: begin
				if (c == CH_PLUS || c == CH_MINUS)
					scan = M_EXP_SIGN;
				else if (ch_digit(c))
					scan = M_EXP_DIG;
				else
					add_error(tok_pos, ERR_EXPONENT, 8'h00);
			end
			M_EXP_SIGN: begin
				if (ch_digit(c))
					scan = M_EXP_DIG;
				else
					add_error(tok_pos, ERR_EXPONENT, 8'h00);
			end
			M_IDENT: begin
				if (!ch_word(c)) begin
					add_token(KIND_IDENT, tok_pos, p - tok_pos, ERR_NONE, 8'h00);
					open_token(c, p);
				end
			end
			M_STAR: begin
				if (c == CH_STAR) begin
					add_token(KIND_POW, tok_pos, 2, ERR_NONE, 8'h00);
					scan = M_IDLE;
				end else begin
					add_token(KIND_MUL, tok_pos, 1, ERR_NONE, 8'h00);
					open_token(c, p);
				end
			end
			M_DOT_LEAD: begin
				if (ch_digit(c))
					scan = M_FRAC;
				else
					add_error(tok_pos, ERR_UNEXPECTED, CH_DOT);
			end
			M_ERROR: begin
			end
			default: open_token(c, p);
		endcase
	endfunction

	// end of expression: flush what is pending, then End unless in error
	function automatic void finish_expr();
		int unsigned back;
		back = (byte_pos > 0) ? byte_pos - 1 : 0;
		case (scan)
			M_INT, M_FRAC, M_EXP_DIG:
				add_token(KIND_NUM, tok_pos, byte_pos - tok_pos, ERR_NONE, 8'h00);
			M_INT_DOT: begin
				add_token(KIND_NUM, tok_pos, back - tok_pos, ERR_NONE, 8'h00);
				add_error(back, ERR_UNEXPECTED, CH_DOT);
			end
			M_DOT_LEAD: add_error(tok_pos, ERR_UNEXPECTED, CH_DOT);
			M_EXP, M_EXP_SIGN: add_error(tok_pos, ERR_EXPONENT, 8'h00);
			M_IDENT: add_token(KIND_IDENT, tok_pos, byte_pos - tok_pos, ERR_NONE, 8'h00);
			M_STAR: add_token(KIND_MUL, tok_pos, 1, ERR_NONE, 8'h00);
			default: begin
			end
		endcase
		if (scan != M_ERROR)
			add_token(KIND_END, byte_pos, 0, ERR_NONE, 8'h00);
		scan     = M_IDLE;
		tok_pos  = 0;
		byte_pos = 0;
	endfunction

	// all tokens caused by one input item, last one flagged
	function automatic void lex_item(input logic [7:0] c, input logic has, input logic fin);
		int unsigned p;
		res_t        r;
		step_n = 0;
		if (has) begin
			p = byte_pos;
			if (byte_pos < POS_TOP)
				byte_pos++;
			scan_byte(c, p);
		end
		if (fin)
			finish_expr();
		for (int i = 0; i < step_n; i++) begin
			r      = step_res[i];
			r.last = (i == step_n - 1);
			tokens_due.insert(tokens_due.size(), r);
		end
	endfunction

	// sample both channels at the rising edge
	always @(posedge clk) begin : watch
		res_t got;
		res_t want;
		if (!arst_n) begin
			scan     = M_IDLE;
			tok_pos  = 0;
			byte_pos = 0;
			tokens_due.delete();
		end else begin
			if (s_tvalid && s_tready)
				lex_item(s_tdata, s_tuser[0], s_tlast);
			if (m_tvalid && m_tready) begin
				got.kind  = m_tuser[3:0];
				got.start = m_tdata[15:0];
				got.len   = m_tdata[31:16];
				got.err   = m_tuser[5:4];
				got.bad   = m_tdata[39:32];
				got.last  = m_tlast;
				if (tokens_due.size() == 0) begin
					fails++;
					$display("%0t ns: result with none expected: kind=%0d start=%0d",
						$time, got.kind, got.start,
						" len=%0d err=%0d bad=%02h last=%0d",
						got.len, got.err, got.bad, got.last);
				end else begin
					want = tokens_due.pop_front();
					if (got !== want) begin
						fails++;
						$display("%0t ns: token mismatch: expected kind=%0d start=%0d",
							$time, want.kind, want.start,
							" len=%0d err=%0d bad=%02h last=%0d",
							want.len, want.err, want.bad, want.last,
							", actual kind=%0d start=%0d len=%0d err=%0d",
							got.kind, got.start, got.len, got.err,
							" bad=%02h last=%0d", got.bad, got.last);
					end
				end
			end
		end
		pending = tokens_due.size();
	end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stream stimulus for the expression tokenizer, with verdict and watchdog.
// ----------------------------------------------------------------------------
// Feeds expression text one byte item at a time: a short hand-written set of
// expressions covering all token kinds but plus, lone dots, bad exponents,
// stray bytes and bare end markers, then randomly built expressions, mostly
// well formed with some noise. Both sides idle in random bursts; the
// receiver holds off once for a long stretch and the sender once waits for
// all tokens to drain. Checking is done by token_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import aet_pkg::*;

	localparam int ITEM_COUNT   = 380;
	localparam int QUIET_ITEMS  = 60;
	localparam int HOLD_CYCLES  = 48;
	localparam int STUCK_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 12;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;     // [7:0] char_byte
	logic [0:0]  s_axis_tuser;     // [0] has_char
	logic        s_axis_tlast;     // is_last
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;     // [15:0] token_start, [31:16] token_length,
	                               // [39:32] bad_char
	logic [5:0]  m_axis_tuser;     // [3:0] token_kind, [5:4] error_code
	logic        m_axis_tlast;     // last_of_run

	int          fails;
	int          pending;
	int          stuck_cycles;
	int          items_sent;
	int          expr_no;
	bit          quiet;
	bit          hold_req;
	bit          tx_steady;
	logic [7:0]  text_q [$];

	arithmetic_expression_tokenizer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	token_checker u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tdata  (s_axis_tdata),
		.s_tuser  (s_axis_tuser),
		.s_tlast  (s_axis_tlast),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tuser  (m_axis_tuser),
		.m_tlast  (m_axis_tlast),
		.fails    (fails),
		.pending  (pending)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// no handshake on either side for too long ends the run
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("%0t ns: no item moved for %0d cycles", $time, STUCK_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// result side: random stall bursts, one long hold-off on request
	initial begin : receiver
		bit rx_steady;
		rx_steady     = 1'b0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 39) == 0)
				rx_steady = !rx_steady;
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (!quiet && !rx_steady && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// one byte item, with an occasional gap before it
	task automatic send_item(input logic [7:0] ch, input logic has, input logic fin);
		if ($urandom_range(0, 31) == 0)
			tx_steady = !tx_steady;
		if (!quiet && !hold_req && !tx_steady && $urandom_range(0, 4) == 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ch;
		s_axis_tuser  <= has;
		s_axis_tlast  <= fin;
		do
			@(posedge clk);
		while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic send_text(input string s, input bit close);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b1, close && (i == s.len() - 1));
	endtask

	function automatic logic [7:0] rand_digit();
		return 8'h30 + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 1))
			return 8'h61 + 8'($urandom_range(0, 25));
		return 8'h41 + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_word_char();
		case ($urandom_range(0, 5))
			0:       return rand_digit();
			1:       return CH_UNDER;
			default: return rand_letter();
		endcase
	endfunction

	function automatic logic [7:0] rand_op();
		case ($urandom_range(0, 9))
			0:       return CH_PLUS;
			1:       return CH_MINUS;
			2:       return CH_STAR;
			3:       return CH_SLASH;
			4:       return CH_CARET;
			5:       return CH_PCT;
			6:       return CH_LPAR;
			7:       return CH_RPAR;
			8:       return CH_EQ;
			default: return CH_COMMA;
		endcase
	endfunction

	// append one byte to the expression text
	function automatic void add_byte(input logic [7:0] b);
		text_q.insert(text_q.size(), b);
	endfunction

	// append one random piece of expression text
	function automatic void add_piece();
		case ($urandom_range(0, 19))
			0, 1, 2, 3: begin
				// number, maybe with fraction and exponent
				repeat ($urandom_range(1, 3)) add_byte(rand_digit());
				if ($urandom_range(0, 1)) begin
					add_byte(CH_DOT);
					repeat ($urandom_range(1, 2)) add_byte(rand_digit());
				end
				if ($urandom_range(0, 3) == 0) begin
					add_byte($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
					case ($urandom_range(0, 2))
						0:       add_byte(CH_PLUS);
						1:       add_byte(CH_MINUS);
						default: begin
						end
					endcase
					repeat ($urandom_range(1, 2)) add_byte(rand_digit());
				end
			end
			4, 5, 6: begin
				add_byte($urandom_range(0, 4) == 0 ? CH_UNDER : rand_letter());
				repeat ($urandom_range(0, 4)) add_byte(rand_word_char());
			end
			7: begin
				add_byte(CH_STAR);
				add_byte(CH_STAR);
			end
			12, 13: begin
				if ($urandom_range(0, 2) == 0)
					add_byte(8'h09 + 8'($urandom_range(0, 4)));
				else
					add_byte(CH_SPACE);
			end
			14: add_byte(8'($urandom_range(0, 255)));
			15: begin
				// malformed numbers
				case ($urandom_range(0, 3))
					0: add_byte(CH_DOT);
					1: begin
						add_byte(rand_digit());
						add_byte(CH_DOT);
					end
					2: begin
						add_byte(rand_digit());
						add_byte(CH_E_LO);
					end
					default: begin
						add_byte(rand_digit());
						add_byte(CH_E_UP);
						add_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
					end
				endcase
			end
			default: add_byte(rand_op());
		endcase
	endfunction

	// one random expression, ended on its last byte or by a bare end marker
	task automatic send_expr();
		bit close_on_byte;
		text_q.delete();
		close_on_byte = ($urandom_range(0, 1) != 0);
		repeat ($urandom_range(0, 9)) add_piece();
		foreach (text_q[i]) begin
			if ($urandom_range(0, 15) == 0)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_item(text_q[i], 1'b1, close_on_byte && (i == text_q.size() - 1));
		end
		if (!close_on_byte || text_q.size() == 0)
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	// stimulus and verdict
	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		s_axis_tuser  = 1'b0;
		s_axis_tlast  = 1'b0;
		items_sent    = 0;
		expr_no       = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// number with fraction and signed exponent, power, identifier
		send_text("1.5e+3**a_9", 1'b1);
		// every single-byte operator but plus
		send_text("(-/%^=,)", 1'b1);
		// pending star flushed by a bare end, after an item carrying nothing
		send_text("2*", 1'b0);
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		// dot after a number, then stray bytes discarded up to the end
		send_text("7.x", 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1);
		// exponent cut off by the end
		send_text("1e", 1'b1);
		// NUL as an unexpected byte
		send_item(8'h00, 1'b1, 1'b1);

		// random expressions
		while (items_sent < ITEM_COUNT) begin
			if (expr_no == 5)
				hold_req = 1'b1;
			if (expr_no == 15) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				while (pending != 0) @(negedge clk);
			end
			if (items_sent >= ITEM_COUNT - QUIET_ITEMS)
				quiet = 1'b1;
			send_expr();
			expr_no++;
		end

		// drain
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: arithmetic_expression_tokenizer.f
+incdir+rtl
rtl/aet_pkg.sv
rtl/aet_core.sv
rtl/arithmetic_expression_tokenizer.sv
rtl/aet_checker.sv
bench/token_checker.sv
bench/testbench.sv
